// File: hw/rtl/bef_pkg.sv
`timescale 1ns / 1ps

package bef_pkg;

  localparam int COORD_W      = 25;
  localparam int SEGMENTS_DEF = 32;
  localparam int IN_TDATA_W   = 8 * COORD_W;
  localparam int SEG_W        = 4 * COORD_W;
  localparam int OUT_TDATA_W  = ((SEG_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - SEG_W;

  typedef enum logic [1:0] {
    OP_LINE  = 2'd0,
    OP_QUAD  = 2'd1,
    OP_CUBIC = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one axis of a curve, c0 start, c3 end; a quadratic leaves c2 at zero
  typedef struct packed {
    coord_t c3;
    coord_t c2;
    coord_t c1;
    coord_t c0;
  } axis_t;

  typedef struct packed {
    axis_t y;
    axis_t x;
  } curve_t;

  typedef struct packed {
    op_t    op;
    curve_t crv;
  } cmd_t;

  typedef struct packed {
    coord_t ey;
    coord_t ex;
    coord_t sy;
    coord_t sx;
  } seg_t;

  typedef struct packed {
    axis_t hi;
    axis_t lo;
  } axis_split_t;

  typedef struct packed {
    curve_t hi;
    curve_t lo;
  } split_t;

  // subdivision levels for a given segment budget
  function automatic int bef_levels(input int segs);
    int m;
    int l;
    m = segs;
    l = 1;
    for (int i = 0; i < 8; i++) begin
      if (m > 2) begin
        m = m >> 1;
        l++;
      end
    end
    return l;
  endfunction

  // divide by 2**k, truncating toward zero
  function automatic coord_t bef_trunc(input logic signed [27:0] v, input logic [1:0] k);
    logic signed [27:0] bias;
    logic signed [27:0] t;
    bias = v[27] ? ((28'sd1 <<< k) - 28'sd1) : 28'sd0;
    t = (v + bias) >>> k;
    return t[COORD_W-1:0];
  endfunction

  function automatic axis_split_t bef_half(input axis_t p, input logic cubic);
    logic signed [25:0] a;
    logic signed [25:0] b;
    logic signed [25:0] c;
    logic signed [27:0] ab;
    logic signed [27:0] bc;
    coord_t m;
    axis_split_t r;
    if (cubic) begin
      a  = 26'(p.c0) + 26'(p.c1);
      b  = 26'(p.c1) + 26'(p.c2);
      c  = 26'(p.c2) + 26'(p.c3);
      ab = 28'(a) + 28'(b);
      bc = 28'(b) + 28'(c);
      m  = bef_trunc(ab + bc, 2'd3);
      r.lo = '{c0: p.c0, c1: bef_trunc(28'(a), 2'd1), c2: bef_trunc(ab, 2'd2), c3: m};
      r.hi = '{c0: m, c1: bef_trunc(bc, 2'd2), c2: bef_trunc(28'(c), 2'd1), c3: p.c3};
    end else begin
      a  = 26'(p.c0) + 26'(p.c1);
      b  = 26'(p.c1) + 26'(p.c3);
      c  = '0;
      ab = 28'(a) + 28'(b);
      bc = 28'(c);
      m  = bef_trunc(ab + bc, 2'd2);
      r.lo = '{c0: p.c0, c1: bef_trunc(28'(a), 2'd1), c2: '0, c3: m};
      r.hi = '{c0: m, c1: bef_trunc(28'(b), 2'd1), c2: '0, c3: p.c3};
    end
    return r;
  endfunction

  function automatic split_t bef_split(input curve_t c, input logic cubic);
    axis_split_t sx;
    axis_split_t sy;
    split_t r;
    sx = bef_half(c.x, cubic);
    sy = bef_half(c.y, cubic);
    r.lo = '{x: sx.lo, y: sy.lo};
    r.hi = '{x: sx.hi, y: sy.hi};
    return r;
  endfunction

endpackage

// File: hw/rtl/bef_front.sv
`timescale 1ns / 1ps

module bef_front (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bef_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              q_full,
  output logic                              q_push,
  output bef_pkg::cmd_t                     cmd
);
  import bef_pkg::*;

  coord_t sx, sy, c1x, c1y, c2x, c2y, ex, ey;

  assign sx  = s_axis_tdata[0*COORD_W +: COORD_W];
  assign sy  = s_axis_tdata[1*COORD_W +: COORD_W];
  assign c1x = s_axis_tdata[2*COORD_W +: COORD_W];
  assign c1y = s_axis_tdata[3*COORD_W +: COORD_W];
  assign c2x = s_axis_tdata[4*COORD_W +: COORD_W];
  assign c2y = s_axis_tdata[5*COORD_W +: COORD_W];
  assign ex  = s_axis_tdata[6*COORD_W +: COORD_W];
  assign ey  = s_axis_tdata[7*COORD_W +: COORD_W];

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    cmd.op  = op_t'(s_axis_tuser);
    cmd.crv = '0;
    case (op_t'(s_axis_tuser))
      OP_LINE: begin
        cmd.crv.x = '{c0: sx, c1: '0, c2: '0, c3: ex};
        cmd.crv.y = '{c0: sy, c1: '0, c2: '0, c3: ey};
      end
      OP_QUAD: begin
        cmd.crv.x = '{c0: sx, c1: c1x, c2: '0, c3: ex};
        cmd.crv.y = '{c0: sy, c1: c1y, c2: '0, c3: ey};
      end
      OP_CUBIC: begin
        cmd.crv.x = '{c0: sx, c1: c1x, c2: c2x, c3: ex};
        cmd.crv.y = '{c0: sy, c1: c1y, c2: c2y, c3: ey};
      end
      default: begin
        cmd.op  = OP_BAD;
        cmd.crv = '0;
      end
    endcase
  end

endmodule

// File: hw/rtl/bef_fifo.sv
`timescale 1ns / 1ps

module bef_fifo #(
  parameter int Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             valid
);

  logic [Width-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        mem[wp] <= wdata;
        wp      <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: hw/rtl/bef_back.sv
`timescale 1ns / 1ps

module bef_back #(
  parameter int Segments = bef_pkg::SEGMENTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bef_pkg::cmd_t  cmd,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output bef_pkg::seg_t  seg,
  output logic           seg_bad,
  output logic           seg_last
);
  import bef_pkg::*;

  localparam int Levels = bef_levels(Segments);
  localparam int Depth  = (Levels < 2) ? 2 : Levels;
  localparam int IdxW   = $clog2(Depth);
  localparam logic [IdxW-1:0] LeafLvl = IdxW'(Levels - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_SECOND
  } state_t;

  state_t          state;
  curve_t          cur;
  logic            cubic;
  logic [IdxW-1:0] lvl;
  logic [IdxW-1:0] sp;
  curve_t          stk_crv [Depth];
  logic [IdxW-1:0] stk_lvl [Depth];

  split_t          halves;
  logic            out_free;
  logic            is_curve;
  logic [IdxW-1:0] pop_idx;
  logic            seg_load;

  assign halves   = bef_split(cur, cubic);
  assign out_free = !out_valid || out_ready;
  assign is_curve = (cmd.op == OP_QUAD) || (cmd.op == OP_CUBIC);
  assign pop_idx  = sp - 1'b1;
  assign cmd_pop  = (state == S_IDLE) && cmd_valid && (is_curve || out_free);
  assign seg_load = out_free &&
                    (((state == S_IDLE) && cmd_valid && !is_curve) ||
                     ((state == S_SPLIT) && (lvl == LeafLvl)) ||
                     (state == S_SECOND));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      sp        <= '0;
      lvl       <= '0;
    end else begin
      out_valid <= seg_load || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (is_curve) begin
              cur   <= cmd.crv;
              cubic <= (cmd.op == OP_CUBIC);
              lvl   <= '0;
              sp    <= '0;
              state <= S_SPLIT;
            end else if (out_free) begin
              // line passes through, undefined kind arrives zeroed
              seg       <= '{sx: cmd.crv.x.c0, sy: cmd.crv.y.c0,
                             ex: cmd.crv.x.c3, ey: cmd.crv.y.c3};
              seg_bad   <= (cmd.op == OP_BAD);
              seg_last  <= 1'b1;
            end
          end
        end
        S_SPLIT: begin
          if (lvl != LeafLvl) begin
            stk_crv[sp] <= halves.hi;
            stk_lvl[sp] <= lvl + 1'b1;
            sp          <= sp + 1'b1;
            cur         <= halves.lo;
            lvl         <= lvl + 1'b1;
          end else if (out_free) begin
            seg       <= '{sx: cur.x.c0, sy: cur.y.c0,
                           ex: halves.lo.x.c3, ey: halves.lo.y.c3};
            seg_bad   <= 1'b0;
            seg_last  <= 1'b0;
            cur       <= halves.hi;
            state     <= S_SECOND;
          end
        end
        S_SECOND: begin
          if (out_free) begin
            seg       <= '{sx: cur.x.c0, sy: cur.y.c0, ex: cur.x.c3, ey: cur.y.c3};
            seg_bad   <= 1'b0;
            seg_last  <= (sp == '0);
            if (sp == '0) begin
              state <= S_IDLE;
            end else begin
              cur   <= stk_crv[pop_idx];
              lvl   <= stk_lvl[pop_idx];
              sp    <= pop_idx;
              state <= S_SPLIT;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/bezier_edge_flattener.sv
`timescale 1ns / 1ps

// channel   dir  tdata                                  tuser      tlast
// s_axis    in   edge points, 200 bits                  edge_kind  -
// m_axis    out  line segment, 100 bits + 4 pad bits    bad_kind   last
//
// a line or an undefined kind gives one item
// a curve is subdivided depth first with a stack of right halves into 2**L segments,
// L = levels from SEGMENTS (32 segments for SEGMENTS = 32), one split per cycle unless
// a leaf waits on a stalled output
// a two-entry command queue lets the input side accept up to two commands while the back end works
// reset clears the queue, the back-end state and the output valid

module bezier_edge_flattener #(
  parameter int SEGMENTS = bef_pkg::SEGMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
  input  logic [bef_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // edge_kind
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, zero pad
  output logic [bef_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // bad_kind
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);
  import bef_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  seg_t seg;

  bef_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .cmd           (front_cmd)
  );

  bef_fifo #(
    .Width ($bits(cmd_t))
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (back_cmd),
    .valid (q_valid)
  );

  bef_back #(
    .Segments (SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .seg       (seg),
    .seg_bad   (m_axis_tuser),
    .seg_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, seg};

endmodule

// File: hw/rtl/bef_checker.sv
`timescale 1ns / 1ps

module bef_port_checks (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [bef_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input logic [1:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bef_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tuser,
  input logic                             m_axis_tlast
);
  import bef_pkg::*;

  logic   out_acc;
  logic   mid_run;
  coord_t prev_ex;
  coord_t prev_ey;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  // track the end point of the last segment of an unfinished run
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_run <= 1'b0;
    end else if (out_acc) begin
      mid_run <= !m_axis_tlast;
      prev_ex <= m_axis_tdata[2*COORD_W +: COORD_W];
      prev_ey <= m_axis_tdata[3*COORD_W +: COORD_W];
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0) && !mid_run)
    else $error("bad kind item not a lone zeroed item");

  a_chain: assert property (@(posedge clk) disable iff (rst)
    out_acc && mid_run |->
      (m_axis_tdata[0*COORD_W +: COORD_W] == prev_ex) &&
      (m_axis_tdata[1*COORD_W +: COORD_W] == prev_ey) && !m_axis_tuser)
    else $error("segment does not start where the previous one ended");

endmodule

bind bezier_edge_flattener bef_port_checks u_bef_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/bef_checker.sv
`timescale 1ns / 1ps

module bef_checker
  import bef_pkg::*;
#(
  parameter int SEGMENTS = SEGMENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     fail_count,
  output int                     pending
);

  // control points of one axis; a quadratic ends at p2 and leaves p3 unused
  typedef struct packed {
    coord_t p3;
    coord_t p2;
    coord_t p1;
    coord_t p0;
  } ctl_axis_t;

  typedef struct packed {
    ctl_axis_t y;
    ctl_axis_t x;
  } bez_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   bad;
    logic   last;
  } seg_exp_t;

  seg_exp_t seg_q[$];
  int       n_queued;
  int       n_retired;

  assign pending = n_queued - n_retired;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void halve_axis(input ctl_axis_t p, input bit cubic,
                                     output ctl_axis_t lo, output ctl_axis_t hi);
    longint a;
    longint b;
    longint c;
    lo = '0;
    hi = '0;
    a = longint'(p.p0) + longint'(p.p1);
    b = longint'(p.p1) + longint'(p.p2);
    lo.p0 = p.p0;
    lo.p1 = coord_t'(a / 2);
    if (cubic) begin
      c = longint'(p.p2) + longint'(p.p3);
      lo.p2 = coord_t'((a + b) / 4);
      lo.p3 = coord_t'((a + 2 * b + c) / 8);
      hi.p0 = lo.p3;
      hi.p1 = coord_t'((b + c) / 4);
      hi.p2 = coord_t'(c / 2);
      hi.p3 = p.p3;
    end else begin
      lo.p2 = coord_t'((a + b) / 4);
      hi.p0 = lo.p2;
      hi.p1 = coord_t'(b / 2);
      hi.p2 = p.p2;
    end
  endfunction

  function automatic void queue_segments(input op_t kind, input logic [IN_TDATA_W-1:0] d);
    coord_t   pt[8];
    bez_t     work[$];
    bez_t     nxt[$];
    bez_t     cur;
    bez_t     lo;
    bez_t     hi;
    int       levels;
    int       m;
    bit       cubic;
    seg_exp_t s;
    for (int i = 0; i < 8; i++) pt[i] = d[i*COORD_W +: COORD_W];
    s = '0;
    case (kind)
      OP_LINE: begin
        s.sx = pt[0];
        s.sy = pt[1];
        s.ex = pt[6];
        s.ey = pt[7];
        s.last = 1'b1;
        seg_q.push_back(s);
        n_queued++;
      end
      OP_BAD: begin
        s.bad = 1'b1;
        s.last = 1'b1;
        seg_q.push_back(s);
        n_queued++;
      end
      default: begin
        cubic = (kind == OP_CUBIC);
        cur = '0;
        cur.x.p0 = pt[0];
        cur.y.p0 = pt[1];
        cur.x.p1 = pt[2];
        cur.y.p1 = pt[3];
        if (cubic) begin
          cur.x.p2 = pt[4];
          cur.y.p2 = pt[5];
          cur.x.p3 = pt[6];
          cur.y.p3 = pt[7];
        end else begin
          cur.x.p2 = pt[6];
          cur.y.p2 = pt[7];
        end
        levels = 1;
        m = SEGMENTS;
        while (m > 2) begin
          m = m / 2;
          levels++;
        end
        work.push_back(cur);
        repeat (levels) begin
          nxt.delete();
          foreach (work[i]) begin
            halve_axis(work[i].x, cubic, lo.x, hi.x);
            halve_axis(work[i].y, cubic, lo.y, hi.y);
            nxt.push_back(lo);
            nxt.push_back(hi);
          end
          work = nxt;
        end
        foreach (work[i]) begin
          s.sx = work[i].x.p0;
          s.sy = work[i].y.p0;
          s.ex = cubic ? work[i].x.p3 : work[i].x.p2;
          s.ey = cubic ? work[i].y.p3 : work[i].y.p2;
          s.last = (i == work.size() - 1);
          seg_q.push_back(s);
          n_queued++;
        end
      end
    endcase
  endfunction

  task automatic check_segment();
    seg_exp_t w;
    coord_t   gsx;
    coord_t   gsy;
    coord_t   gex;
    coord_t   gey;
    gsx = m_axis_tdata[0*COORD_W +: COORD_W];
    gsy = m_axis_tdata[1*COORD_W +: COORD_W];
    gex = m_axis_tdata[2*COORD_W +: COORD_W];
    gey = m_axis_tdata[3*COORD_W +: COORD_W];
    if (seg_q.size() == 0) begin
      report("item with nothing expected, seg_start_x", gsx, 0);
    end else begin
      w = seg_q.pop_front();
      n_retired++;
      if (gsx != w.sx) report("seg_start_x", gsx, w.sx);
      if (gsy != w.sy) report("seg_start_y", gsy, w.sy);
      if (gex != w.ex) report("seg_end_x", gex, w.ex);
      if (gey != w.ey) report("seg_end_y", gey, w.ey);
      if (m_axis_tdata[OUT_TDATA_W-1:SEG_W] != '0) begin
        report("tdata pad", m_axis_tdata[OUT_TDATA_W-1:SEG_W], 0);
      end
      if (m_axis_tuser != w.bad) report("bad_kind", m_axis_tuser, w.bad);
      if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) queue_segments(op_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_segment();
    end
  end

endmodule

// File: tb/sv/bezier_edge_flattener_tb.sv
`timescale 1ns / 1ps

module bezier_edge_flattener_tb;
  import bef_pkg::*;

  localparam int     CYCLE_LIMIT = 200000;
  localparam coord_t CMAX        = 25'sh0FFFFFF;
  localparam coord_t CMIN        = 25'sh1000000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // edge_kind
  logic [1:0]             s_axis_tuser = OP_LINE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // bad_kind
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  logic                   calm = 1'b0;
  int                     cycles = 0;
  int                     fail_count;
  int                     pending;

  always #5 clk = ~clk;

  bezier_edge_flattener #(
    .SEGMENTS(SEGMENTS_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  bef_checker #(
    .SEGMENTS(SEGMENTS_DEF)
  ) chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("bezier_edge_flattener_tb failed");
      $finish;
    end
  end

  function automatic coord_t any_coord();
    int v;
    case ($urandom_range(3))
      0, 1: return coord_t'($urandom);
      2: begin
        v = int'($urandom_range(1023)) - 512;
        return coord_t'(v);
      end
      default: begin
        case ($urandom_range(3))
          0: return CMAX;
          1: return CMIN;
          2: return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic op_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 15) return OP_LINE;
    if (r < 50) return OP_QUAD;
    if (r < 90) return OP_CUBIC;
    return OP_BAD;
  endfunction

  task automatic send_edge(input op_t kind, input coord_t sx, input coord_t sy,
                           input coord_t c1x, input coord_t c1y,
                           input coord_t c2x, input coord_t c2y,
                           input coord_t ex, input coord_t ey);
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ey, ex, c2y, c2x, c1y, c1x, sy, sx};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lines, degenerate line, ignored control points
    send_edge(OP_LINE, CMAX, CMIN, 0, 0, 0, 0, CMIN, CMAX);
    send_edge(OP_LINE, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_edge(OP_LINE, 12345, -6789, any_coord(), any_coord(), any_coord(), any_coord(),
              12345, -6789);
    // undefined kind
    send_edge(OP_BAD, any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
              any_coord(), any_coord(), any_coord());
    send_edge(OP_BAD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_edge(OP_BAD, 0, 0, 0, 0, 0, 0, 0, 0);
    // quadratics at the range limits and near zero
    send_edge(OP_QUAD, 0, 0, 0, 0, 0, 0, 0, 0);
    send_edge(OP_QUAD, CMAX, CMAX, CMAX, CMAX, 0, 0, CMAX, CMAX);
    send_edge(OP_QUAD, CMIN, CMIN, CMIN, CMIN, 0, 0, CMIN, CMIN);
    send_edge(OP_QUAD, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX);
    send_edge(OP_QUAD, -1, -3, -5, 2, CMIN, CMAX, -3, -1);
    send_edge(OP_QUAD, 777, -777, 777, -777, 0, 0, 777, -777);
    // cubics at the range limits and near zero
    send_edge(OP_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0);
    send_edge(OP_CUBIC, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
    send_edge(OP_CUBIC, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
    send_edge(OP_CUBIC, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN);
    send_edge(OP_CUBIC, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX);
    send_edge(OP_CUBIC, -1, -2, -7, -3, -5, 1, -3, -9);
    send_edge(OP_CUBIC, 1, 3, 5, 7, 9, 11, 13, 15);
    send_edge(OP_LINE, CMIN, CMIN, 0, 0, 0, 0, CMAX, CMAX);

    for (int n = 0; n < 80; n++) begin
      calm <= (n >= 25 && n < 55);
      send_edge(pick_kind(), any_coord(), any_coord(), any_coord(), any_coord(),
                any_coord(), any_coord(), any_coord(), any_coord());
    end
    s_axis_tvalid <= 1'b0;

    // let the checker take in the last accepted item first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("bezier_edge_flattener_tb passed");
    end else begin
      $display("bezier_edge_flattener_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bef_pkg.sv
hw/rtl/bef_front.sv
hw/rtl/bef_fifo.sv
hw/rtl/bef_back.sv
hw/rtl/bezier_edge_flattener.sv
hw/rtl/bef_checker.sv
tb/sv/bef_checker.sv
tb/sv/bezier_edge_flattener_tb.sv
